// ===== hdl/steepest_ascent_direction_3x3_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef STEEPEST_ASCENT_DIRECTION_3X3_UNIT_MACROS_SVH
`define STEEPEST_ASCENT_DIRECTION_3X3_UNIT_MACROS_SVH

// check while out of reset
`define SAD3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define SAD3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sad3_pkg.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: package
// Widths, stream packing, lane and candidate types, selection helpers.
// ----------------------------------------------------------------------------
package sad3_pkg;

  localparam int HEIGHT_BITS   = 16;
  localparam int GRAD_BITS     = 16;
  localparam int NUM_NEIGH     = 8;
  localparam int IDX_BITS      = $clog2(NUM_NEIGH);
  localparam int DIR_BITS      = IDX_BITS + 1;
  localparam int FIRST_DIAG    = 4;
  localparam int DIAG_NUM      = 181;
  localparam int DIAG_NUM_BITS = 8;
  localparam int DIAG_SHIFT    = 8;
  localparam int PROD_BITS     = HEIGHT_BITS + DIAG_NUM_BITS;
  localparam int SAT_BITS      = (HEIGHT_BITS > GRAD_BITS) ? HEIGHT_BITS : GRAD_BITS;

  localparam int IN_FIELD_BITS  = HEIGHT_BITS * (NUM_NEIGH + 1) + NUM_NEIGH;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = DIR_BITS + 1 + GRAD_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [DIR_BITS-1:0]  NO_DIR   = DIR_BITS'(NUM_NEIGH);
  localparam logic [GRAD_BITS-1:0] GRAD_MAX = {GRAD_BITS{1'b1}};

  typedef logic [HEIGHT_BITS-1:0] height_t;

  typedef struct packed {
    logic    higher;
    height_t rise;
  } lane_res_t;

  typedef struct packed {
    logic                found;
    height_t             rise;
    logic [IDX_BITS-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic [GRAD_BITS-1:0] grad;
    logic                 peak;
    logic [DIR_BITS-1:0]  dir;
  } result_t;

  // lower index in a wins ties
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    r = (b.found && (!a.found || (b.rise > a.rise))) ? b : a;
    return r;
  endfunction

  function automatic logic [GRAD_BITS-1:0] sat_grad(height_t rise);
    logic [SAT_BITS-1:0] rx;
    logic [SAT_BITS-1:0] mx;
    rx = SAT_BITS'(rise);
    mx = SAT_BITS'(GRAD_MAX);
    return (rx > mx) ? GRAD_MAX : GRAD_BITS'(rx);
  endfunction

endpackage

// ===== hdl/steepest_ascent_direction_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: top level
// Picks the steepest strictly higher neighbour of a 3x3 heightmap window.
// ----------------------------------------------------------------------------
// Takes one window per clock while the output is not stalled and returns
// one result per window. Eight lanes compare each neighbour with the centre
// and scale diagonal rises by 181/256 in the first register stage; a
// three-level selection tree (lowest index wins ties) feeds the output
// register in the second. A stalled output holds its result while the lane
// stage still takes one more window.
module steepest_ascent_direction_3x3_unit
  import sad3_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // center, north, south, west, east, northwest, northeast, southwest,
  // southeast heights (16 bits each), present_mask (8 bits)
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // ascent_direction (4), is_peak (1), best_gradient (16), zero padding
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  height_t                centre;
  height_t                hts [NUM_NEIGH];
  logic [NUM_NEIGH-1:0]   mask;
  lane_res_t              lanes [NUM_NEIGH];
  result_t                res;
  logic                   adv2;
  logic                   v1_r;
  logic                   v1_nxt;
  logic                   v2_r;
  logic                   v2_nxt;

  always_comb begin
    centre = in_tdata[HEIGHT_BITS-1:0];
    for (int i = 0; i < NUM_NEIGH; i++) begin
      hts[i] = in_tdata[(i+1)*HEIGHT_BITS +: HEIGHT_BITS];
    end
    mask = in_tdata[(NUM_NEIGH+1)*HEIGHT_BITS +: NUM_NEIGH];
  end

  always_comb begin
    adv2      = !v2_r || out_tready;
    in_tready = !v1_r || adv2;
    v1_nxt    = in_tready ? in_tvalid : v1_r;
    v2_nxt    = adv2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  for (genvar g = 0; g < NUM_NEIGH; g++) begin : g_lane
    sad3_lane u_lane (
      .clk     (clk),
      .en      (in_tready),
      .diag    (1'(g >= FIRST_DIAG)),
      .present (mask[g]),
      .height  (hts[g]),
      .centre  (centre),
      .res     (lanes[g])
    );
  end

  sad3_merge u_merge (
    .clk   (clk),
    .en    (adv2),
    .lanes (lanes),
    .res   (res)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = OUT_DATA_BITS'(res);

endmodule

// ===== hdl/sad3_lane.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: neighbour lane
// Tests one neighbour against the centre and registers its scaled rise.
// ----------------------------------------------------------------------------
module sad3_lane
  import sad3_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  logic      diag,
  input  logic      present,
  input  height_t   height,
  input  height_t   centre,
  output lane_res_t res
);

  height_t                diff;
  logic [PROD_BITS-1:0]   prod;
  lane_res_t              res_nxt;
  lane_res_t              res_r;

  always_comb begin
    diff           = height - centre;
    prod           = PROD_BITS'(diff) * PROD_BITS'(DIAG_NUM);
    res_nxt.higher = present && (height > centre);
    res_nxt.rise   = diag ? prod[HEIGHT_BITS+DIAG_SHIFT-1:DIAG_SHIFT] : diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/sad3_merge.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: merge stage
// Reduces the lane results to the steepest rise and registers the result.
// ----------------------------------------------------------------------------
module sad3_merge
  import sad3_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  lane_res_t lanes [NUM_NEIGH],
  output result_t   res
);

  cand_t   lvl0 [NUM_NEIGH];
  cand_t   lvl1 [NUM_NEIGH/2];
  cand_t   lvl2 [NUM_NEIGH/4];
  cand_t   best;
  result_t res_nxt;
  result_t res_r;

  always_comb begin
    for (int i = 0; i < NUM_NEIGH; i++) begin
      lvl0[i].found = lanes[i].higher;
      lvl0[i].rise  = lanes[i].rise;
      lvl0[i].idx   = IDX_BITS'(i);
    end
    for (int i = 0; i < NUM_NEIGH/2; i++) begin
      lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
    end
    for (int i = 0; i < NUM_NEIGH/4; i++) begin
      lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    best         = pick(lvl2[0], lvl2[1]);
    res_nxt.peak = !best.found;
    res_nxt.dir  = best.found ? DIR_BITS'(best.idx) : NO_DIR;
    res_nxt.grad = best.found ? sat_grad(best.rise) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/sad3_checker.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: port checker
// Watches the result stream for consistency and bound to the top level.
// ----------------------------------------------------------------------------
`include "steepest_ascent_direction_3x3_unit_macros.svh"

module sad3_checker
  import sad3_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  result_t res;
  logic    stall;
  logic    peak_out;
  logic    slope_out;
  logic    peak_clean;

  assign res        = result_t'(out_tdata[OUT_FIELD_BITS-1:0]);
  assign stall      = out_tvalid && !out_tready;
  assign peak_out   = out_tvalid && res.peak;
  assign slope_out  = out_tvalid && !res.peak;
  assign peak_clean = (res.dir == NO_DIR) && (res.grad == '0);

  `SAD3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `SAD3_ASSERT(a_peak_fields, peak_out |-> peak_clean, "peak with direction or gradient")
  `SAD3_ASSERT(a_dir_range, slope_out |-> (res.dir < NO_DIR), "non-peak without a direction")
  `SAD3_ASSERT(a_stall_hold, stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind steepest_ascent_direction_3x3_unit sad3_checker u_sad3_checker (.*);

// ===== tb/tb_steepest_ascent_direction_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// Steepest ascent direction unit: testbench
// Drives 3x3 heightmap windows through the stream input, expects direction,
// peak flag and gradient for each accepted window, and checks every result
// transaction in order. A short table of corner-case windows comes first,
// then random windows under four idling and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_steepest_ascent_direction_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sad3_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 100;
  localparam int PAD_BITS      = OUT_DATA_BITS - OUT_FIELD_BITS;

  typedef struct packed {
    logic [NUM_NEIGH-1:0]                mask;
    logic [NUM_NEIGH-1:0][HEIGHT_BITS-1:0] neighbour;
    height_t                             centre;
  } window_t;

  typedef struct packed {
    logic [PAD_BITS-1:0]  pad;
    logic [GRAD_BITS-1:0] grad;
    logic                 peak;
    logic [DIR_BITS-1:0]  dir;
  } ascent_t;

  typedef struct {
    window_t win;
    bit      known;
    ascent_t want;
  } row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  ascent_t ascent_q[$];
  int      error_count;
  int      idle_cycles;
  int      send_idle_pct;
  int      recv_stall_pct;

  steepest_ascent_direction_3x3_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic ascent_t outcome(logic [DIR_BITS-1:0] dir, logic peak,
                                      logic [GRAD_BITS-1:0] grad);
    ascent_t r;
    r      = '0;
    r.dir  = dir;
    r.peak = peak;
    r.grad = grad;
    return r;
  endfunction

  function automatic window_t win(logic [7:0] m, height_t c,
                                  height_t n0, height_t n1, height_t n2, height_t n3,
                                  height_t n4, height_t n5, height_t n6, height_t n7);
    window_t w;
    w.mask         = m;
    w.centre       = c;
    w.neighbour[0] = n0;
    w.neighbour[1] = n1;
    w.neighbour[2] = n2;
    w.neighbour[3] = n3;
    w.neighbour[4] = n4;
    w.neighbour[5] = n5;
    w.neighbour[6] = n6;
    w.neighbour[7] = n7;
    return w;
  endfunction

  function automatic ascent_t predict_ascent(window_t w);
    ascent_t              r;
    logic                 found;
    logic [PROD_BITS-1:0] rise;
    logic [PROD_BITS-1:0] best;
    r     = outcome(NO_DIR, 1'b1, '0);
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < NUM_NEIGH; i++) begin
      if (w.mask[i] && (w.neighbour[i] > w.centre)) begin
        rise = PROD_BITS'(w.neighbour[i]) - PROD_BITS'(w.centre);
        if (i >= FIRST_DIAG) begin
          rise = PROD_BITS'((rise * DIAG_NUM) >> DIAG_SHIFT);
        end
        if (!found || (rise > best)) begin
          found = 1'b1;
          best  = rise;
          r.dir = DIR_BITS'(i);
        end
      end
    end
    if (found) begin
      r.peak = 1'b0;
      r.grad = (best > PROD_BITS'(GRAD_MAX)) ? GRAD_MAX : GRAD_BITS'(best);
    end
    return r;
  endfunction

  function automatic height_t near_height(height_t c);
    height_t h;
    case ($urandom_range(7))
      0:       h = height_t'($urandom);
      1:       h = c;
      2:       h = c + 1'b1;
      3:       h = c - 1'b1;
      4:       h = c + height_t'($urandom_range(15));
      5:       h = '1;
      6:       h = '0;
      default: h = c + height_t'($urandom_range(1023));
    endcase
    return h;
  endfunction

  function automatic window_t random_window();
    window_t w;
    int      src;
    int      dst;
    case ($urandom_range(3))
      0:       w.centre = height_t'($urandom);
      1:       w.centre = height_t'($urandom_range(255));
      2:       w.centre = height_t'($urandom_range(65535, 65280));
      default: w.centre = height_t'($urandom_range(40000, 20000));
    endcase
    for (int i = 0; i < NUM_NEIGH; i++) begin
      w.neighbour[i] = ($urandom_range(3) == 0) ? height_t'($urandom)
                                                : near_height(w.centre);
    end
    if ($urandom_range(3) == 0) begin
      src = $urandom_range(NUM_NEIGH - 1);
      dst = $urandom_range(NUM_NEIGH - 1);
      w.neighbour[dst] = w.neighbour[src];
    end
    case ($urandom_range(3))
      0, 1:    w.mask = 8'($urandom);
      2:       w.mask = '1;
      default: w.mask = 8'($urandom) & 8'($urandom);
    endcase
    return w;
  endfunction

  task automatic send_window(input window_t w, input ascent_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    ascent_q.push_back(want);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ascent_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    ascent_t got;
    ascent_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = ascent_t'(out_tdata);
      if (ascent_q.size() == 0) begin
        $display("%0t: unexpected result dir=%0d peak=%0d grad=%0d",
                 $time, got.dir, got.peak, got.grad);
        error_count++;
      end else begin
        want = ascent_q.pop_front();
        if (got.dir !== want.dir) begin
          $display("%0t: ascent_direction expected %0d actual %0d",
                   $time, want.dir, got.dir);
          error_count++;
        end
        if (got.peak !== want.peak) begin
          $display("%0t: is_peak expected %0d actual %0d", $time, want.peak, got.peak);
          error_count++;
        end
        if (got.grad !== want.grad) begin
          $display("%0t: best_gradient expected %0d actual %0d",
                   $time, want.grad, got.grad);
          error_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    row_t directed_rows[$];
    int   phase;
    error_count    = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;

    directed_rows.push_back('{win(8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              outcome(NO_DIR, 1'b1, 0)});
    directed_rows.push_back('{win(8'hFF, 65535, 65535, 65535, 65535, 65535,
                                  65535, 65535, 65535, 65535), 1'b1,
                              outcome(NO_DIR, 1'b1, 0)});
    directed_rows.push_back('{win(8'h00, 0, 65535, 65535, 65535, 65535,
                                  65535, 65535, 65535, 65535), 1'b1,
                              outcome(NO_DIR, 1'b1, 0)});
    directed_rows.push_back('{win(8'hFF, 0, 65535, 65535, 65535, 65535,
                                  65535, 65535, 65535, 65535), 1'b1,
                              outcome(0, 1'b0, 65535)});
    directed_rows.push_back('{win(8'h01, 0, 65535, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              outcome(0, 1'b0, 65535)});
    directed_rows.push_back('{win(8'h80, 0, 0, 0, 0, 0, 0, 0, 0, 65535), 1'b1,
                              outcome(7, 1'b0, 46335)});
    directed_rows.push_back('{win(8'h10, 100, 0, 0, 0, 0, 101, 0, 0, 0), 1'b1,
                              outcome(4, 1'b0, 0)});
    directed_rows.push_back('{win(8'hF0, 65534, 0, 0, 0, 0, 65535, 65535, 65535, 65535),
                              1'b1, outcome(4, 1'b0, 0)});
    directed_rows.push_back('{win(8'hFF, 65534, 65535, 65535, 65535, 65535,
                                  65535, 65535, 65535, 65535), 1'b1,
                              outcome(0, 1'b0, 1)});
    directed_rows.push_back('{win(8'hFF, 100, 100, 100, 100, 100, 100, 100, 100, 100),
                              1'b1, outcome(NO_DIR, 1'b1, 0)});
    directed_rows.push_back('{win(8'hFF, 65535, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              outcome(NO_DIR, 1'b1, 0)});
    directed_rows.push_back('{win(8'hFF, 10, 20, 0, 0, 20, 0, 0, 0, 0), 1'b1,
                              outcome(0, 1'b0, 10)});
    directed_rows.push_back('{win(8'hFF, 0, 0, 0, 50, 50, 0, 0, 0, 0), 1'b1,
                              outcome(2, 1'b0, 50)});
    directed_rows.push_back('{win(8'h02, 100, 5000, 200, 0, 0, 0, 0, 0, 0), 1'b1,
                              outcome(1, 1'b0, 100)});
    directed_rows.push_back('{win(8'hFF, 1000, 1300, 1600, 1900, 2200,
                                  2500, 2800, 3100, 3400), 1'b0, '0});
    directed_rows.push_back('{win(8'h0F, 1000, 1300, 1600, 1900, 2200,
                                  2500, 2800, 3100, 3400), 1'b0, '0});
    directed_rows.push_back('{win(8'h11, 0, 181, 0, 0, 0, 256, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{win(8'h28, 0, 0, 0, 0, 180, 0, 256, 0, 0), 1'b0, '0});
    directed_rows.push_back('{win(8'hAA, 16'h5555, 16'hAAAA, 16'h5556, 16'hAAAA,
                                  16'h5556, 16'hAAAA, 16'h5556, 16'hAAAA, 16'h5556),
                              1'b0, '0});
    directed_rows.push_back('{win(8'h55, 16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF,
                                  16'h8000, 16'h8002, 16'h0001, 16'hC000, 16'h8003),
                              1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_window(directed_rows[i].win,
                  directed_rows[i].known ? directed_rows[i].want
                                         : predict_ascent(directed_rows[i].win));
    end

    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      repeat (RANDOM_ITEMS) begin
        window_t w;
        w = random_window();
        send_window(w, predict_ascent(w));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
